/* hdl/sks_pkg.sv */
// Shared types and constants for the sorted key set table.
// Used by sks_cell, sorted_key_set_table_top and the bench; depends on nothing.
package sks_pkg;

  localparam int KEY_W        = 47;
  localparam int CMD_W        = 2;
  localparam int OUT_NUM_W    = 9;
  localparam int DEF_CAPACITY = 256;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Per-cycle instruction broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_en;   // compare the stored key against the request key
    logic ins_en;   // open a gap at the insertion point and drop the key in
    logic rem_en;   // close the gap at the matching key
  } sks_ctrl_t;

endpackage

/* hdl/sks_cell.sv */
// One cell of the sorted key chain: holds a single key and its compare flags.
// Depends on sks_pkg; instantiated in a row by sorted_key_set_table_top.
module sks_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sks_pkg::sks_ctrl_t       ctrl,
  input  logic                     valid,     // this slot lies below the fill count
  input  logic [sks_pkg::KEY_W-1:0] key_in,   // request key, broadcast
  input  logic                     lt_prev,   // lower neighbour holds a smaller key
  input  logic [sks_pkg::KEY_W-1:0] key_prev, // lower neighbour's key
  input  logic [sks_pkg::KEY_W-1:0] key_next, // upper neighbour's key
  output logic [sks_pkg::KEY_W-1:0] key_o,
  output logic                     lt_o,
  output logic                     eq_o
);

  logic [sks_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      lt_r, lt_nxt;
  logic                      eq_r, eq_nxt;

  always_comb begin
    key_nxt = key_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (ctrl.cmp_en) begin
      lt_nxt = valid && (key_r < key_in);
      eq_nxt = valid && (key_r == key_in);
    end
    // cells holding smaller keys stay put; the rest shift
    if (ctrl.ins_en && !lt_r) begin
      key_nxt = lt_prev ? key_in : key_prev;
    end
    if (ctrl.rem_en && !lt_r) begin
      key_nxt = key_next;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  assign key_o = key_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;

endmodule

/* hdl/sks_tree.sv */
// Registered reduction tree over the cell flags: counts smaller keys and ORs matches.
// Depends on no other file; one register level per tree level.
module sks_tree #(
  parameter int LEAVES = 256
) (
  input  logic                        clk,
  input  logic [LEAVES-1:0]           lt,
  input  logic [LEAVES-1:0]           eq,
  output logic [$clog2(LEAVES):0]     pos,
  output logic                        found
);

  localparam int LOGC  = $clog2(LEAVES);
  localparam int P2    = 1 << LOGC;
  localparam int NODES = P2 - 1;
  localparam int W     = LOGC + 1;

  logic [W-1:0]     cnt_r [NODES];
  logic [NODES-1:0] fnd_r;

  for (genvar n = 0; n < NODES; n++) begin : g_node
    localparam int CL = 2 * n + 1;
    localparam int CR = 2 * n + 2;
    logic [W-1:0] cl, cr;
    logic         fl, fr;

    if (CL >= NODES) begin : g_left_leaf
      if (CL - NODES < LEAVES) begin : g_real
        assign cl = W'(lt[CL-NODES]);
        assign fl = eq[CL-NODES];
      end else begin : g_pad
        assign cl = '0;
        assign fl = 1'b0;
      end
    end else begin : g_left_node
      assign cl = cnt_r[CL];
      assign fl = fnd_r[CL];
    end

    if (CR >= NODES) begin : g_right_leaf
      if (CR - NODES < LEAVES) begin : g_real
        assign cr = W'(lt[CR-NODES]);
        assign fr = eq[CR-NODES];
      end else begin : g_pad
        assign cr = '0;
        assign fr = 1'b0;
      end
    end else begin : g_right_node
      assign cr = cnt_r[CR];
      assign fr = fnd_r[CR];
    end

    always_ff @(posedge clk) begin
      cnt_r[n] <= cl + cr;
      fnd_r[n] <= fl | fr;
    end
  end

  assign pos   = cnt_r[0];
  assign found = fnd_r[0];

endmodule

/* hdl/sorted_key_set_table_top.sv */
// Sorted key set table: a chain of compare-and-shift cells holding unique keys
// in ascending order, with a registered count tree. Depends on sks_pkg,
// sks_cell and sks_tree.
// Flow: the cells compare (S_CMP), the count tree sums (S_SUM) and the result is
//   registered in S_UPD; the tree depth LOGC = clog2(CAPACITY) sets the S_SUM stay.
// One request in flight at a time; S_UPD holds while an earlier result still waits.
// Reset: fill count and handshake state cleared, table empty; key cells keep
//   whatever they held, and no clearing pass runs.
module sorted_key_set_table_top #(
  parameter int CAPACITY = sks_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [46:0] item_number, [47] zero
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [8:0] position, [17:9] entry_count, [23:18] zero
  output logic [1:0]  out_tuser   // [0] found, [1] full_reject
);

  localparam int LOGC   = $clog2(CAPACITY);
  localparam int POS_W  = LOGC + 1;
  localparam int WAIT_W = $clog2(LOGC + 1);
  localparam int KW     = sks_pkg::KEY_W;
  localparam int OW     = sks_pkg::OUT_NUM_W;

  localparam logic [POS_W-1:0]  CAP_V     = POS_W'(CAPACITY);
  localparam logic [WAIT_W-1:0] WAIT_LAST = WAIT_W'(LOGC - 1);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_SUM, S_UPD} state_t;

  state_t                     state_r;
  logic [WAIT_W-1:0]          wait_r;
  logic [POS_W-1:0]           count_r;
  logic [KW-1:0]              key_r;
  logic [sks_pkg::CMD_W-1:0]  cmd_r;
  logic                       out_valid_r;
  logic                       out_found_r;
  logic                       out_reject_r;
  logic [OW-1:0]              out_pos_r;
  logic [OW-1:0]              out_count_r;

  sks_pkg::sks_ctrl_t ctrl;
  logic               in_acc;
  logic               upd_go;
  logic               is_add, is_rem;
  logic               tree_found;
  logic [POS_W-1:0]   tree_pos;
  logic               full;
  logic [POS_W-1:0]   count_nxt;
  logic [POS_W+OW-1:0] pos_ext, count_ext;

  logic [KW-1:0]       key_w [CAPACITY];
  logic [CAPACITY-1:0] lt_w, eq_w;

  // ---------------------------------------------------------------- control
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // hold the update while an earlier result still waits at the output
  assign upd_go    = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign full      = (count_r == CAP_V);

  always_comb begin
    is_add = 1'b0;
    is_rem = 1'b0;
    unique case (cmd_r)
      sks_pkg::CMD_ADD:    is_add = 1'b1;
      sks_pkg::CMD_REMOVE: is_rem = 1'b1;
      default:             ; // lookup, and the unused code behaves as lookup
    endcase
  end

  always_comb begin
    ctrl.cmp_en = (state_r == S_CMP);
    ctrl.ins_en = upd_go && is_add && !tree_found && !full;
    ctrl.rem_en = upd_go && is_rem && tree_found;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + POS_W'(1);
    end else if (ctrl.rem_en) begin
      count_nxt = count_r - POS_W'(1);
    end
  end

  // report position and count modulo the 9-bit field width
  assign pos_ext   = {{OW{1'b0}}, tree_pos};
  assign count_ext = {{OW{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result unless a new one lands in the same cycle
      if (out_valid_r && out_tready && !upd_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          wait_r  <= '0;
          state_r <= S_SUM;
        end
        S_SUM: begin
          // advance until the tree root has seen every leaf
          wait_r <= wait_r + WAIT_W'(1);
          if (wait_r == WAIT_LAST) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_go) begin
            count_r      <= count_nxt;
            out_valid_r  <= 1'b1;
            out_found_r  <= tree_found;
            out_reject_r <= is_add && !tree_found && full;
            out_pos_r    <= pos_ext[OW-1:0];
            out_count_r  <= count_ext[OW-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // request payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_tdata[KW-1:0];
      cmd_r <= in_tuser;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_count_r, out_pos_r};
  assign out_tuser  = {out_reject_r, out_found_r};

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic          valid;
    logic          lt_prev;
    logic [KW-1:0] key_prev, key_next;

    assign valid = (count_r > POS_W'(i));

    if (i == 0) begin : g_first
      // the bottom cell always sees an open slot below it
      assign lt_prev  = 1'b1;
      assign key_prev = key_r;
    end else begin : g_mid
      assign lt_prev  = lt_w[i-1];
      assign key_prev = key_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign key_next = key_w[i];
    end else begin : g_below_top
      assign key_next = key_w[i+1];
    end

    sks_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .valid    (valid),
      .key_in   (key_r),
      .lt_prev  (lt_prev),
      .key_prev (key_prev),
      .key_next (key_next),
      .key_o    (key_w[i]),
      .lt_o     (lt_w[i]),
      .eq_o     (eq_w[i])
    );
  end

  // ---------------------------------------------------------------- count tree
  sks_tree #(
    .LEAVES (CAPACITY)
  ) u_tree (
    .clk   (clk),
    .lt    (lt_w),
    .eq    (eq_w),
    .pos   (tree_pos),
    .found (tree_found)
  );

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_V)
    else $error("fill count above capacity");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && tree_found) |-> (tree_pos < count_r))
    else $error("match reported at or beyond fill count");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_en |=> (count_r == $past(count_r) + POS_W'(1)))
    else $error("insert did not grow the table by one");

  a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rem_en |=> (count_r == $past(count_r) - POS_W'(1)))
    else $error("remove did not shrink the table by one");

  a_reject_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reject_r) |-> (!out_found_r && count_r == CAP_V))
    else $error("full reject without a full table or with a match");

endmodule

/* dv/tb.sv */
// Self-checking bench for sorted_key_set_table_top: directed table, then random waves
// that fill the table to capacity, overflow it and drain it again.
// Depends on sks_pkg and the sorted key set table RTL.
module tb;

  localparam int TBL_CAP  = sks_pkg::DEF_CAPACITY;
  localparam int CMD_W    = sks_pkg::CMD_W;
  localparam int KEY_W    = sks_pkg::KEY_W;
  localparam int NUM_W    = sks_pkg::OUT_NUM_W;
  // request-to-result latency plus the turnaround before the next request
  localparam int RESP_LAT = $clog2(TBL_CAP) + 3;

  // command 3 is not decoded by the block and must behave as a lookup
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX   = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_TOP   = 47'd99999999999999;
  localparam logic             CHK       = 1'b1;  // row carries a typed answer
  localparam logic             PRD       = 1'b0;  // row is checked against the predictor
  localparam int               N_DIR     = 22;

  typedef struct packed {
    logic             found;
    logic [NUM_W-1:0] pos;
    logic [NUM_W-1:0] cnt;
    logic             rej;
  } tbl_resp_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic             typed;
    tbl_resp_t        resp;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // [46:0] item_number, [47] zero
  logic [1:0]  in_tuser   = '0;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [23:0] out_tdata;         // [8:0] position, [17:9] entry_count, [23:18] zero
  logic [1:0]  out_tuser;         // [0] found, [1] full_reject

  // Shadow copy of the table held in ascending order
  logic [KEY_W-1:0] shadow_keys [TBL_CAP];
  int               shadow_fill;

  tbl_resp_t  pending_resp_q [$];
  dir_row_t   dir_rows [N_DIR];
  logic       idle_on = 1'b1;

  int n_req, n_resp, n_mismatch, n_reject, n_hit, n_full_hit, peak_fill;

  sorted_key_set_table_top #(.CAPACITY(TBL_CAP)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one request to the shadow table and return the result it must give.
  // The insertion point is the count of stored keys below the request key.
  task automatic apply_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                               output tbl_resp_t r);
    int  ins;
    bit  hit;
    ins = 0;
    while (ins < shadow_fill && shadow_keys[ins] < key) ins++;
    hit   = (ins < shadow_fill) && (shadow_keys[ins] == key);
    r.rej = 1'b0;
    if (cmd == sks_pkg::CMD_ADD && !hit) begin
      if (shadow_fill >= TBL_CAP) begin
        r.rej = 1'b1;
      end else begin
        for (int i = shadow_fill; i > ins; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[ins] = key;
        shadow_fill++;
      end
    end else if (cmd == sks_pkg::CMD_REMOVE && hit) begin
      for (int i = ins; i < shadow_fill - 1; i++) shadow_keys[i] = shadow_keys[i+1];
      shadow_fill--;
    end
    r.found = hit;
    r.pos   = ins[NUM_W-1:0];
    r.cnt   = shadow_fill[NUM_W-1:0];
  endtask

  // Offer one request, hold it until taken, then log what must come back.
  // A typed row overrides the predicted answer but still advances the shadow.
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic typed, input tbl_resp_t typed_resp);
    int        gap;
    tbl_resp_t pred;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_request(cmd, key, pred);
    pending_resp_q.push_back(typed ? typed_resp : pred);
    n_req++;
    if (pred.rej) n_reject++;
    if (pred.found) n_hit++;
    if (pred.found && cmd == sks_pkg::CMD_ADD && shadow_fill == TBL_CAP) n_full_hit++;
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    // switch idling off for some stretches so back-to-back traffic is seen too
    if (n_req % 64 == 0) idle_on <= ($urandom_range(0, 3) != 0);
  endtask

  // Stop sending and hold off until every outstanding result has arrived
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_resp_q.size() != 0);
  endtask

  // Present keys, neighbours of present keys, or fresh keys of random magnitude
  function automatic logic [KEY_W-1:0] pick_key(int present_pct);
    logic [63:0]      raw;
    logic [KEY_W-1:0] base;
    int               w;
    int               r;
    r = $urandom_range(0, 99);
    if (shadow_fill > 0 && r < present_pct + 10) begin
      base = shadow_keys[$urandom_range(0, shadow_fill - 1)];
      if (r < present_pct) return base;
      return $urandom_range(0, 1) ? base + 1'b1 : base - 1'b1;
    end
    raw = {$urandom(), $urandom()};
    w   = $urandom_range(1, KEY_W);
    return raw[KEY_W-1:0] & ~(KEY_MAX << w);
  endfunction

  task automatic random_item(input int add_pct, input int rem_pct, input int present_pct);
    logic [CMD_W-1:0] cmd;
    int               r;
    r = $urandom_range(0, 99);
    if (r < add_pct)                cmd = sks_pkg::CMD_ADD;
    else if (r < add_pct + rem_pct) cmd = sks_pkg::CMD_REMOVE;
    else if (r < 97)                cmd = sks_pkg::CMD_LOOKUP;
    else                            cmd = CMD_SPARE;
    send_req(cmd, pick_key(present_pct), PRD, '0);
  endtask

  // Receiver: stall at random while idling is on
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Check every result taken against the oldest outstanding request
  always @(posedge clk) begin
    tbl_resp_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.found = out_tuser[0];
      got.rej   = out_tuser[1];
      got.pos   = out_tdata[8:0];
      got.cnt   = out_tdata[17:9];
      n_resp++;
      if (pending_resp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("result with no request outstanding: found=%0d pos=%0d cnt=%0d rej=%0d",
                   got.found, got.pos, got.cnt, got.rej);
      end else begin
        want = pending_resp_q.pop_front();
        if (got.found !== want.found || got.pos !== want.pos ||
            got.cnt !== want.cnt || got.rej !== want.rej) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"result %0d wrong: exp found=%0d pos=%0d cnt=%0d rej=%0d, ",
                      "got found=%0d pos=%0d cnt=%0d rej=%0d"},
                     n_resp, want.found, want.pos, want.cnt, want.rej,
                     got.found, got.pos, got.cnt, got.rej);
        end
      end
    end
  end

  initial begin
    int n;
    shadow_fill = 0;
    n_req = 0; n_resp = 0; n_mismatch = 0; n_reject = 0;
    n_hit = 0; n_full_hit = 0; peak_fill = 0;

    // Directed table: empty table, key extremes, duplicates, spare command,
    // removal of absent keys and alternating bit patterns
    dir_rows = '{
      '{sks_pkg::CMD_LOOKUP, 47'd0,            CHK, '{1'b0, 9'd0, 9'd0, 1'b0}},
      '{sks_pkg::CMD_REMOVE, 47'd5,            CHK, '{1'b0, 9'd0, 9'd0, 1'b0}},
      '{sks_pkg::CMD_ADD,    KEY_MAX,          CHK, '{1'b0, 9'd0, 9'd1, 1'b0}},
      '{sks_pkg::CMD_ADD,    47'd0,            CHK, '{1'b0, 9'd0, 9'd2, 1'b0}},
      '{sks_pkg::CMD_ADD,    KEY_MAX,          CHK, '{1'b1, 9'd1, 9'd2, 1'b0}},
      '{sks_pkg::CMD_LOOKUP, KEY_MAX,          CHK, '{1'b1, 9'd1, 9'd2, 1'b0}},
      '{sks_pkg::CMD_ADD,    KEY_TOP,          CHK, '{1'b0, 9'd1, 9'd3, 1'b0}},
      '{CMD_SPARE,           47'd0,            CHK, '{1'b1, 9'd0, 9'd3, 1'b0}},
      '{sks_pkg::CMD_LOOKUP, 47'd5,            CHK, '{1'b0, 9'd1, 9'd3, 1'b0}},
      '{sks_pkg::CMD_REMOVE, 47'd0,            CHK, '{1'b1, 9'd0, 9'd2, 1'b0}},
      '{sks_pkg::CMD_REMOVE, 47'd0,            CHK, '{1'b0, 9'd0, 9'd2, 1'b0}},
      '{sks_pkg::CMD_ADD,    47'd1,            CHK, '{1'b0, 9'd0, 9'd3, 1'b0}},
      '{sks_pkg::CMD_ADD,    47'h2AAAAAAAAAAA, PRD, '0},
      '{sks_pkg::CMD_ADD,    47'h555555555555, PRD, '0},
      '{CMD_SPARE,           KEY_MAX,          PRD, '0},
      '{sks_pkg::CMD_REMOVE, KEY_MAX,          PRD, '0},
      '{sks_pkg::CMD_LOOKUP, KEY_MAX,          PRD, '0},
      '{sks_pkg::CMD_REMOVE, KEY_TOP,          PRD, '0},
      '{sks_pkg::CMD_ADD,    47'd2,            PRD, '0},
      '{sks_pkg::CMD_LOOKUP, 47'd3,            PRD, '0},
      '{sks_pkg::CMD_REMOVE, 47'd1,            PRD, '0},
      '{sks_pkg::CMD_ADD,    KEY_MAX - 1'b1,   PRD, '0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_req(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].resp);
    drain_results();

    // Fill wave: mostly fresh adds until the table is full
    n = 0;
    while (shadow_fill < TBL_CAP && n < 450) begin
      random_item(88, 4, 10);
      n++;
    end
    // Overflow: refused adds, adds of present keys on a full table
    repeat (30) random_item(70, 5, 50);
    drain_results();
    // Drain wave: mostly removes of present keys, then a balanced mix
    repeat (130) random_item(15, 70, 75);
    repeat (50) random_item(45, 35, 50);

    drain_results();
    repeat (RESP_LAT * 3) @(posedge clk);

    $display("%0d requests, %0d results; %0d hits, %0d refused adds, %0d present adds on full",
             n_req, n_resp, n_hit, n_reject, n_full_hit);
    $display("peak fill %0d of %0d, %0d mismatches", peak_fill, TBL_CAP, n_mismatch);
    if (n_mismatch == 0 && pending_resp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
